// File: sv/writeback_lru_block_cache_directory_top_macros.svh
// Assertion macros for the cache directory top level.
// Included by writeback_lru_block_cache_directory_top; expects i_clk and i_rst_n in scope.
`ifndef WRITEBACK_LRU_BLOCK_CACHE_DIRECTORY_TOP_MACROS_SVH
`define WRITEBACK_LRU_BLOCK_CACHE_DIRECTORY_TOP_MACROS_SVH

// Check a property that holds in the same cycle.
`define WLCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define WLCD_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// File: sv/wlcd_pkg.sv
// Shared types and codes for the write-back LRU cache directory.
// Used by wlcd_cell and writeback_lru_block_cache_directory_top.
package wlcd_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    // Request operations
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_WT    = 3'd2;
    localparam logic [2:0] OP_INV   = 3'd3;
    localparam logic [2:0] OP_SYNC  = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_WB     = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_WT     = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Final status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_NULL_DEV = 3'd1;
    localparam logic [2:0] STAT_NO_VICT  = 3'd2;
    localparam logic [2:0] STAT_RD_FAIL  = 3'd3;
    localparam logic [2:0] STAT_WR_FAIL  = 3'd4;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_FRONT,
        RK_BACK
    } t_rank_op;

    // Command broadcast to every cell
    typedef struct packed {
        t_rank_op    rank_op;
        logic        snap;
        logic        wr_tag;
        logic        clr_dev;
        logic        wr_valid;
        logic        valid_val;
        logic        wr_dirty;
        logic        dirty_val;
    } t_cell_cmd;

    // Per-cell status seen by the sequencer
    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic        match;
        logic [3:0]  device;
        logic [31:0] block;
    } t_cell_st;

endpackage

// File: sv/wlcd_cell.sv
// One directory slot: tag, valid, dirty, recency rank and walk snapshot.
// Depends on wlcd_pkg.
module wlcd_cell #(
    parameter int NUM_SLOTS = wlcd_pkg::NUM_SLOTS_DEF,
    parameter int IDX       = 0,
    parameter int SW        = $clog2(NUM_SLOTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wlcd_pkg::t_cell_cmd i_cmd,
    input  logic [3:0]          i_key_dev,
    input  logic [31:0]         i_key_blk,
    input  logic                i_sel,
    input  logic [SW-1:0]       i_ref_rank,
    output wlcd_pkg::t_cell_st  o_st,
    output logic [SW-1:0]       o_rank,
    output logic [SW-1:0]       o_snap
);
    import wlcd_pkg::*;

    localparam logic [SW-1:0] RANK_RST  = SW'(NUM_SLOTS - 1 - IDX);
    localparam logic [SW-1:0] RANK_LAST = SW'(NUM_SLOTS - 1);

    logic          r_valid;
    logic          r_dirty;
    logic [SW-1:0] r_rank;
    logic [SW-1:0] r_snap;
    logic [3:0]    r_dev;
    logic [31:0]   r_blk;

    // Update control bits and recency rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= RANK_RST;
        end else begin
            unique case (i_cmd.rank_op)
                RK_FRONT: begin
                    if (i_sel) begin
                        r_rank <= '0;
                    end else if (r_rank < i_ref_rank) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                RK_BACK: begin
                    if (i_sel) begin
                        r_rank <= RANK_LAST;
                    end else if (r_rank > i_ref_rank) begin
                        r_rank <= r_rank - 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_sel && i_cmd.wr_valid) begin
                r_valid <= i_cmd.valid_val;
            end
            if (i_sel && i_cmd.wr_dirty) begin
                r_dirty <= i_cmd.dirty_val;
            end
        end
    end

    // Hold tag and walk snapshot
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            r_snap <= r_rank;
        end
        if (i_sel && i_cmd.wr_tag) begin
            r_dev <= i_key_dev;
            r_blk <= i_key_blk;
        end else if (i_sel && i_cmd.clr_dev) begin
            r_dev <= '0;
        end
    end

    assign o_st.valid  = r_valid;
    assign o_st.dirty  = r_dirty;
    assign o_st.match  = r_valid && (r_dev == i_key_dev) && (r_blk == i_key_blk);
    assign o_st.device = r_dev;
    assign o_st.block  = r_blk;
    assign o_rank      = r_rank;
    assign o_snap      = r_snap;

endmodule

// File: sv/writeback_lru_block_cache_directory_top.sv
// Write-back LRU block cache directory: a row of slot cells and a request sequencer.
// Depends on wlcd_pkg, wlcd_cell and the top-level assertion macro header.
//
// Usage: one request channel (i_valid / o_stall) carries operation, device, block
// address and the disk failure flags; one result channel (o_valid / i_stall) returns
// disk commands (writeback, fill, write-through) followed by one final status with
// o_last high. The block takes one request at a time; o_stall is high until the
// final status has entered the output register.
// Steps after a request is accepted: a hit, invalidate, null device or unknown
// operation goes from decode to the final status; a write-through adds the
// write-through command first; a miss walks the victims, takes a slot and, for a read,
// fills it, and a dirty slot whose writeback fails sends the walk on to the next
// slot; a sync visits every slot once. Each cycle the sequencer reads one cell,
// unless the receiver stalls a pending result.
// Reset empties every slot and sets the recency order to the highest slot most
// recent, slot 0 least recent. While the receiver stalls, the output register
// holds its result and the sequencer waits before its next transfer.
`include "writeback_lru_block_cache_directory_top_macros.svh"
module writeback_lru_block_cache_directory_top #(
    parameter int NUM_SLOTS = wlcd_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [3:0]  i_device,
    input  logic [31:0] i_block_address,
    input  logic        i_write_fails,
    input  logic        i_read_fails,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_slot,
    output logic [3:0]  o_target_device,
    output logic [31:0] o_target_block,
    output logic        o_hit,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import wlcd_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_TAKE  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_WT    = 3'd5;
    localparam logic [2:0] S_SYNC  = 3'd6;
    localparam logic [2:0] S_FINAL = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [3:0]    r_dev, n_dev;
    logic [31:0]   r_blk, n_blk;
    logic          r_wf, n_wf;
    logic          r_rf, n_rf;
    logic          r_hit_o, n_hit_o;
    logic          r_found, n_found;
    logic [2:0]    r_status, n_status;
    logic [SW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_k, n_k;
    logic [SW-1:0] r_c, n_c;
    logic [SW-1:0] r_i, n_i;

    logic          r_ov;
    logic [1:0]    r_kind;
    logic [4:0]    r_oslot;
    logic [3:0]    r_odev;
    logic [31:0]   r_oblk;
    logic          r_ohit;
    logic [2:0]    r_ostat;
    logic          r_olast;

    t_cell_cmd     w_cmd;
    t_cell_st      w_st [NUM_SLOTS];
    logic [SW-1:0] w_rank [NUM_SLOTS];
    logic [SW-1:0] w_snap [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] w_match;
    logic          w_hit_any;
    logic [SW-1:0] w_hit_idx;
    logic [SW-1:0] w_walk_c;
    logic [SW-1:0] w_tgt;
    t_cell_st      w_cur;
    logic [SW-1:0] w_cur_rank;
    logic          w_qual;
    logic          w_can_emit;
    logic          e_emit;
    logic [1:0]    e_kind;
    logic [SW-1:0] e_slot;
    logic [3:0]    e_dev;
    logic [31:0]   e_blk;
    logic          e_hit;
    logic [2:0]    e_status;
    logic          e_last;
    logic [SW+4:0] w_slot_wide;

    // Row of slot cells
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        wlcd_cell #(
            .NUM_SLOTS (NUM_SLOTS),
            .IDX       (g),
            .SW        (SW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_key_dev  (r_dev),
            .i_key_blk  (r_blk),
            .i_sel      (w_tgt == SW'(g)),
            .i_ref_rank (w_cur_rank),
            .o_st       (w_st[g]),
            .o_rank     (w_rank[g]),
            .o_snap     (w_snap[g])
        );
        assign w_match[g] = w_st[g].match;
    end

    // Encode hit slot and walk slot
    always_comb begin
        w_hit_any = |w_match;
        w_hit_idx = '0;
        w_walk_c  = '0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (w_match[j]) begin
                w_hit_idx = w_hit_idx | SW'(j);
            end
            if (w_snap[j] == r_k) begin
                w_walk_c = w_walk_c | SW'(j);
            end
        end
    end

    // Pick the slot the sequencer works on
    always_comb begin
        unique case (r_state)
            S_DEC:          w_tgt = w_hit_idx;
            S_WALK:         w_tgt = w_walk_c;
            S_TAKE, S_FILL,
            S_WT:           w_tgt = r_c;
            S_SYNC:         w_tgt = r_i;
            default:        w_tgt = r_slot;
        endcase
    end

    assign w_cur      = w_st[w_tgt];
    assign w_cur_rank = w_rank[w_tgt];
    assign w_qual     = w_cur.valid && w_cur.dirty && ((r_dev == 4'd0) || (w_cur.device == r_dev));
    assign w_can_emit = !r_ov || !i_stall;

    // Request sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_dev    = r_dev;
        n_blk    = r_blk;
        n_wf     = r_wf;
        n_rf     = r_rf;
        n_hit_o  = r_hit_o;
        n_found  = r_found;
        n_status = r_status;
        n_slot   = r_slot;
        n_k      = r_k;
        n_c      = r_c;
        n_i      = r_i;
        w_cmd           = '0;
        w_cmd.rank_op   = RK_NONE;
        e_emit   = 1'b0;
        e_kind   = KIND_STATUS;
        e_slot   = '0;
        e_dev    = r_dev;
        e_blk    = r_blk;
        e_hit    = 1'b0;
        e_status = STAT_OK;
        e_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_operation;
                    n_dev    = i_device;
                    n_blk    = i_block_address;
                    n_wf     = i_write_fails;
                    n_rf     = i_read_fails;
                    n_hit_o  = 1'b0;
                    n_status = STAT_OK;
                    n_slot   = '0;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if ((r_op == OP_READ || r_op == OP_WRITE || r_op == OP_WT) && r_dev == 4'd0) begin
                    n_status = STAT_NULL_DEV;
                    n_state  = S_FINAL;
                end else begin
                    unique case (r_op)
                        OP_READ, OP_WRITE: begin
                            if (w_hit_any) begin
                                n_slot        = w_hit_idx;
                                n_hit_o       = 1'b1;
                                w_cmd.rank_op = RK_FRONT;
                                if (r_op == OP_WRITE) begin
                                    w_cmd.wr_valid  = 1'b1;
                                    w_cmd.valid_val = 1'b1;
                                    w_cmd.wr_dirty  = 1'b1;
                                    w_cmd.dirty_val = 1'b1;
                                end
                                n_state = S_FINAL;
                            end else begin
                                w_cmd.snap = 1'b1;
                                n_k        = LAST_IDX;
                                n_state    = S_WALK;
                            end
                        end
                        OP_WT: begin
                            n_found = w_hit_any;
                            n_c     = w_hit_idx;
                            n_state = S_WT;
                        end
                        OP_INV: begin
                            if (w_hit_any) begin
                                n_slot          = w_hit_idx;
                                n_hit_o         = 1'b1;
                                w_cmd.wr_valid  = 1'b1;
                                w_cmd.wr_dirty  = 1'b1;
                                w_cmd.clr_dev   = 1'b1;
                                w_cmd.rank_op   = RK_BACK;
                            end
                            n_state = S_FINAL;
                        end
                        OP_SYNC: begin
                            n_i     = '0;
                            n_state = S_SYNC;
                        end
                        default: n_state = S_FINAL;
                    endcase
                end
            end
            S_WALK: begin
                if (!w_cur.valid || !w_cur.dirty) begin
                    n_c     = w_walk_c;
                    n_state = S_TAKE;
                end else if (w_can_emit) begin
                    e_emit = 1'b1;
                    e_kind = KIND_WB;
                    e_slot = w_walk_c;
                    e_dev  = w_cur.device;
                    e_blk  = w_cur.block;
                    if (!r_wf) begin
                        w_cmd.wr_dirty = 1'b1;
                        n_c            = w_walk_c;
                        n_state        = S_TAKE;
                    end else begin
                        w_cmd.rank_op = RK_FRONT;
                        if (r_k == '0) begin
                            n_status = STAT_NO_VICT;
                            n_slot   = '0;
                            n_state  = S_FINAL;
                        end else begin
                            n_k = r_k - 1'b1;
                        end
                    end
                end
            end
            S_TAKE: begin
                w_cmd.wr_tag    = 1'b1;
                w_cmd.wr_valid  = 1'b1;
                w_cmd.valid_val = (r_op == OP_WRITE);
                w_cmd.wr_dirty  = 1'b1;
                w_cmd.dirty_val = (r_op == OP_WRITE);
                w_cmd.rank_op   = RK_FRONT;
                n_slot          = r_c;
                n_state         = (r_op == OP_WRITE) ? S_FINAL : S_FILL;
            end
            S_FILL: begin
                if (w_can_emit) begin
                    e_emit         = 1'b1;
                    e_kind         = KIND_FILL;
                    e_slot         = r_c;
                    w_cmd.wr_valid = 1'b1;
                    w_cmd.wr_dirty = 1'b1;
                    if (r_rf) begin
                        w_cmd.clr_dev = 1'b1;
                        w_cmd.rank_op = RK_BACK;
                        n_status      = STAT_RD_FAIL;
                    end else begin
                        w_cmd.valid_val = 1'b1;
                    end
                    n_state = S_FINAL;
                end
            end
            S_WT: begin
                if (w_can_emit) begin
                    e_emit = 1'b1;
                    e_kind = KIND_WT;
                    if (r_wf) begin
                        n_status = STAT_WR_FAIL;
                    end else if (r_found) begin
                        n_slot         = r_c;
                        n_hit_o        = 1'b1;
                        w_cmd.wr_dirty = 1'b1;
                        w_cmd.rank_op  = RK_FRONT;
                    end
                    n_state = S_FINAL;
                end
            end
            S_SYNC: begin
                if (!w_qual || w_can_emit) begin
                    if (w_qual) begin
                        e_emit = 1'b1;
                        e_kind = KIND_WB;
                        e_slot = r_i;
                        e_dev  = w_cur.device;
                        e_blk  = w_cur.block;
                        if (r_wf) begin
                            n_status = STAT_WR_FAIL;
                        end else begin
                            w_cmd.wr_dirty = 1'b1;
                        end
                    end
                    if (r_i == LAST_IDX) begin
                        n_state = S_FINAL;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_FINAL: begin
                if (w_can_emit) begin
                    e_emit   = 1'b1;
                    e_kind   = KIND_STATUS;
                    e_slot   = r_slot;
                    e_hit    = r_hit_o;
                    e_status = r_status;
                    e_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold request and walk registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_dev    <= n_dev;
        r_blk    <= n_blk;
        r_wf     <= n_wf;
        r_rf     <= n_rf;
        r_hit_o  <= n_hit_o;
        r_found  <= n_found;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_k      <= n_k;
        r_c      <= n_c;
        r_i      <= n_i;
    end

    assign w_slot_wide = {5'd0, e_slot};

    // Output register: load on emit, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (e_emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_emit) begin
            r_kind  <= e_kind;
            r_oslot <= w_slot_wide[4:0];
            r_odev  <= e_dev;
            r_oblk  <= e_blk;
            r_ohit  <= e_hit;
            r_ostat <= e_status;
            r_olast <= e_last;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_ov;
    assign o_kind          = r_kind;
    assign o_slot          = r_oslot;
    assign o_target_device = r_odev;
    assign o_target_block  = r_oblk;
    assign o_hit           = r_ohit;
    assign o_status        = r_ostat;
    assign o_last          = r_olast;

    // Checks
    `WLCD_ASSERT(a_tag_unique, $onehot0(w_match), "two valid slots hold the same tag")
    `WLCD_ASSERT(a_last_is_status, !(o_valid && o_last) || (o_kind == KIND_STATUS),
        "last result is not a final status")
    `WLCD_ASSERT_NEXT(a_final_loaded, (r_state == S_FINAL) && w_can_emit,
        o_valid && o_last && (r_state == S_IDLE), "final status not loaded")

endmodule
